### rtl/icnf_pkg.sv
// Package for the incremental CNF tokenizer.
// Holds character classes, queue item layout, token kinds and error codes.
// No dependencies.
package icnf_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int CODE_W  = 4;
    localparam int MAG_W   = 31;

    localparam logic [MAG_W-1:0] MAX_MAG = 31'h7FFF_FFFF;

    // ASCII characters the tokenizer reacts to
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_LIT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLAUSE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CUBE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DONE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

    // Error codes
    localparam logic [CODE_W-1:0] ERR_NONE           = 4'd0;
    localparam logic [CODE_W-1:0] ERR_EOF_NO_HDR     = 4'd0;
    localparam logic [CODE_W-1:0] ERR_EOF_HDR_CMT    = 4'd1;
    localparam logic [CODE_W-1:0] ERR_BAD_PRE_HDR    = 4'd2;
    localparam logic [CODE_W-1:0] ERR_BAD_HDR        = 4'd3;
    localparam logic [CODE_W-1:0] ERR_EOF_CMT        = 4'd4;
    localparam logic [CODE_W-1:0] ERR_DOUBLE_A       = 4'd5;
    localparam logic [CODE_W-1:0] ERR_A_OPEN         = 4'd6;
    localparam logic [CODE_W-1:0] ERR_MINUS_NODIGIT  = 4'd7;
    localparam logic [CODE_W-1:0] ERR_MINUS_ZERO     = 4'd8;
    localparam logic [CODE_W-1:0] ERR_UNEXPECTED     = 4'd9;
    localparam logic [CODE_W-1:0] ERR_OVERFLOW       = 4'd10;
    localparam logic [CODE_W-1:0] ERR_CLAUSE_AFTER   = 4'd11;
    localparam logic [CODE_W-1:0] ERR_EOF_OPEN       = 4'd12;
    localparam logic [CODE_W-1:0] ERR_EOF_AFTER_A    = 4'd13;
    localparam logic [CODE_W-1:0] ERR_AFTER_NUMBER   = 4'd14;

    typedef enum logic [3:0] {
        C_EOF,
        C_NL,
        C_BLANK,
        C_LC,
        C_LP,
        C_LA,
        C_MINUS,
        C_ZERO,
        C_DIGIT,
        C_OTHER
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] chr;
    } t_item;

    // Header text after the leading 'p': " inccnf\n"
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CH_SPACE;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h6E;
            3'd3:    c = CH_C;
            3'd4:    c = CH_C;
            3'd5:    c = 8'h6E;
            3'd6:    c = 8'h66;
            default: c = CH_NL;
        endcase
        return c;
    endfunction

endpackage

### rtl/icnf_in_if.sv
// Input channel of the tokenizer: one text byte or the end mark per word.
// Depends on nothing.
interface icnf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

### rtl/icnf_out_if.sv
// Output channel of the tokenizer: one token per word.
// Depends on nothing.
interface icnf_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         token_kind;
    logic signed [31:0] literal_value;
    logic [3:0]         error_code;

    modport source (output valid, output token_kind, output literal_value,
                    output error_code, input ready);
    modport sink   (input valid, input token_kind, input literal_value,
                    input error_code, output ready);
endinterface

### rtl/icnf_classify.sv
// Front end: accepts input words and tags each with its character class.
// Depends on icnf_pkg and icnf_in_if.
module icnf_classify (
    icnf_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output icnf_pkg::t_item  o_item
);

    icnf_pkg::t_cls w_cls;

    always_comb begin
        if (i_in.end_of_input) begin
            w_cls = icnf_pkg::C_EOF;
        end else if (i_in.in_byte == icnf_pkg::CH_NL) begin
            w_cls = icnf_pkg::C_NL;
        end else if (i_in.in_byte == icnf_pkg::CH_SPACE || i_in.in_byte == icnf_pkg::CH_TAB) begin
            w_cls = icnf_pkg::C_BLANK;
        end else if (i_in.in_byte == icnf_pkg::CH_C) begin
            w_cls = icnf_pkg::C_LC;
        end else if (i_in.in_byte == icnf_pkg::CH_P) begin
            w_cls = icnf_pkg::C_LP;
        end else if (i_in.in_byte == icnf_pkg::CH_A) begin
            w_cls = icnf_pkg::C_LA;
        end else if (i_in.in_byte == icnf_pkg::CH_MINUS) begin
            w_cls = icnf_pkg::C_MINUS;
        end else if (i_in.in_byte == icnf_pkg::CH_ZERO) begin
            w_cls = icnf_pkg::C_ZERO;
        end else if (i_in.in_byte > icnf_pkg::CH_ZERO && i_in.in_byte <= icnf_pkg::CH_NINE) begin
            w_cls = icnf_pkg::C_DIGIT;
        end else begin
            w_cls = icnf_pkg::C_OTHER;
        end
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign o_item.cls = w_cls;
    assign o_item.chr = i_in.in_byte;

endmodule

### rtl/icnf_queue.sv
// Short queue of classified words between front and back end.
// Depends on icnf_pkg.
module icnf_queue #(
    parameter int DEPTH = icnf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  icnf_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output icnf_pkg::t_item  o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    icnf_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !w_pop) |=> $stable(r_wr_ptr))
        else $error("queue write pointer moved while full");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");
`endif

endmodule

### rtl/icnf_parse.sv
// Back end: parser state machine that turns classified words into tokens,
// with the output register. Depends on icnf_pkg and icnf_out_if.
module icnf_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  icnf_pkg::t_item  i_item,
    output logic             o_pop,
    icnf_out_if.source       o_out
);

    typedef enum logic [3:0] {
        PH_SEEK,
        PH_HCOMMENT,
        PH_HEADER,
        PH_BODY,
        PH_BCOMMENT,
        PH_MINUS,
        PH_NUMBER,
        PH_NCOMMENT,
        PH_DONE,
        PH_ERROR
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic [2:0]                    r_hdr_pos, n_hdr_pos;
    logic [icnf_pkg::MAG_W-1:0]    r_mag, n_mag;
    logic                          r_neg, n_neg;
    logic                          r_open, n_open;
    logic                          r_cube, n_cube;
    logic                          r_allowed, n_allowed;

    logic                          r_out_valid;
    logic [icnf_pkg::KIND_W-1:0]   r_kind;
    logic [icnf_pkg::VALUE_W-1:0]  r_value;
    logic [icnf_pkg::CODE_W-1:0]   r_code;

    logic                          w_put;
    logic [icnf_pkg::KIND_W-1:0]   w_kind;
    logic [icnf_pkg::VALUE_W-1:0]  w_value;
    logic [icnf_pkg::CODE_W-1:0]   w_code;

    logic [3:0]                    w_digit;
    logic [icnf_pkg::MAG_W+3:0]    w_next_mag;
    logic [icnf_pkg::VALUE_W-1:0]  w_mag_ext;

    assign o_pop   = i_valid && (!r_out_valid || o_out.ready);
    assign w_digit = i_item.chr[3:0];
    assign w_next_mag = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                      + {(icnf_pkg::MAG_W)'(0), w_digit};
    assign w_mag_ext  = {1'b0, r_mag};

    always_comb begin
        n_phase   = r_phase;
        n_hdr_pos = r_hdr_pos;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_open    = r_open;
        n_cube    = r_cube;
        n_allowed = r_allowed;
        w_put     = 1'b0;
        w_kind    = icnf_pkg::KIND_ERROR;
        w_value   = '0;
        w_code    = icnf_pkg::ERR_NONE;

        unique case (r_phase)
            PH_SEEK: begin
                if (i_item.cls == icnf_pkg::C_EOF) begin
                    w_put = 1'b1; w_code = icnf_pkg::ERR_EOF_NO_HDR; n_phase = PH_ERROR;
                end else if (i_item.cls == icnf_pkg::C_LC) begin
                    n_phase = PH_HCOMMENT;
                end else if (i_item.cls == icnf_pkg::C_LP) begin
                    n_phase = PH_HEADER; n_hdr_pos = '0;
                end else begin
                    w_put = 1'b1; w_code = icnf_pkg::ERR_BAD_PRE_HDR; n_phase = PH_ERROR;
                end
            end
            PH_HCOMMENT: begin
                if (i_item.cls == icnf_pkg::C_EOF) begin
                    w_put = 1'b1; w_code = icnf_pkg::ERR_EOF_HDR_CMT; n_phase = PH_ERROR;
                end else if (i_item.cls == icnf_pkg::C_NL) begin
                    n_phase = PH_SEEK;
                end
            end
            PH_HEADER: begin
                if (i_item.cls == icnf_pkg::C_EOF
                        || i_item.chr != icnf_pkg::hdr_char(r_hdr_pos)) begin
                    w_put = 1'b1; w_code = icnf_pkg::ERR_BAD_HDR; n_phase = PH_ERROR;
                end else if (r_hdr_pos == 3'd7) begin
                    n_phase = PH_BODY; n_hdr_pos = '0;
                end else begin
                    n_hdr_pos = r_hdr_pos + 3'd1;
                end
            end
            PH_BODY: begin
                unique case (i_item.cls) inside
                    icnf_pkg::C_EOF: begin
                        w_put = 1'b1;
                        if (r_open) begin
                            w_code = icnf_pkg::ERR_EOF_OPEN; n_phase = PH_ERROR;
                        end else if (r_cube) begin
                            w_code = icnf_pkg::ERR_EOF_AFTER_A; n_phase = PH_ERROR;
                        end else begin
                            w_kind = icnf_pkg::KIND_DONE; n_phase = PH_DONE;
                        end
                    end
                    icnf_pkg::C_NL, icnf_pkg::C_BLANK: begin
                    end
                    icnf_pkg::C_LC: n_phase = PH_BCOMMENT;
                    icnf_pkg::C_LA: begin
                        if (r_cube) begin
                            w_put = 1'b1; w_code = icnf_pkg::ERR_DOUBLE_A; n_phase = PH_ERROR;
                        end else if (r_open) begin
                            w_put = 1'b1; w_code = icnf_pkg::ERR_A_OPEN; n_phase = PH_ERROR;
                        end else begin
                            n_cube = 1'b1;
                        end
                    end
                    icnf_pkg::C_MINUS: n_phase = PH_MINUS;
                    icnf_pkg::C_ZERO, icnf_pkg::C_DIGIT: begin
                        n_mag   = {(icnf_pkg::MAG_W-4)'(0), w_digit};
                        n_neg   = 1'b0;
                        n_phase = PH_NUMBER;
                    end
                    default: begin
                        w_put = 1'b1; w_code = icnf_pkg::ERR_UNEXPECTED; n_phase = PH_ERROR;
                    end
                endcase
            end
            PH_BCOMMENT: begin
                if (i_item.cls == icnf_pkg::C_EOF) begin
                    w_put = 1'b1; w_code = icnf_pkg::ERR_EOF_CMT; n_phase = PH_ERROR;
                end else if (i_item.cls == icnf_pkg::C_NL) begin
                    n_phase = PH_BODY;
                end
            end
            PH_MINUS: begin
                if (i_item.cls == icnf_pkg::C_DIGIT) begin
                    n_mag   = {(icnf_pkg::MAG_W-4)'(0), w_digit};
                    n_neg   = 1'b1;
                    n_phase = PH_NUMBER;
                end else if (i_item.cls == icnf_pkg::C_ZERO) begin
                    w_put = 1'b1; w_code = icnf_pkg::ERR_MINUS_ZERO; n_phase = PH_ERROR;
                end else begin
                    w_put = 1'b1; w_code = icnf_pkg::ERR_MINUS_NODIGIT; n_phase = PH_ERROR;
                end
            end
            PH_NUMBER, PH_NCOMMENT: begin
                // Finish the number on a blank or newline, or on the newline closing a comment.
                if (r_phase == PH_NUMBER
                        && (i_item.cls == icnf_pkg::C_ZERO || i_item.cls == icnf_pkg::C_DIGIT)) begin
                    if (w_next_mag > {4'b0000, icnf_pkg::MAX_MAG}) begin
                        w_put = 1'b1; w_code = icnf_pkg::ERR_OVERFLOW; n_phase = PH_ERROR;
                    end else begin
                        n_mag = w_next_mag[icnf_pkg::MAG_W-1:0];
                    end
                end else if (i_item.cls == icnf_pkg::C_EOF) begin
                    w_put   = 1'b1;
                    w_code  = (r_phase == PH_NUMBER) ? icnf_pkg::ERR_AFTER_NUMBER
                                                     : icnf_pkg::ERR_EOF_CMT;
                    n_phase = PH_ERROR;
                end else if (r_phase == PH_NUMBER && i_item.cls == icnf_pkg::C_LC) begin
                    n_phase = PH_NCOMMENT;
                end else if ((r_phase == PH_NUMBER && i_item.cls == icnf_pkg::C_BLANK)
                        || i_item.cls == icnf_pkg::C_NL) begin
                    w_put   = 1'b1;
                    n_phase = PH_BODY;
                    if (r_mag != '0) begin
                        n_open  = 1'b1;
                        w_kind  = icnf_pkg::KIND_LIT;
                        w_value = r_neg ? (~w_mag_ext + 32'd1) : w_mag_ext;
                    end else if (!r_allowed && !r_cube) begin
                        w_code  = icnf_pkg::ERR_CLAUSE_AFTER;
                        n_phase = PH_ERROR;
                    end else if (r_cube) begin
                        n_open    = 1'b0;
                        n_cube    = 1'b0;
                        n_allowed = 1'b0;
                        w_kind    = icnf_pkg::KIND_CUBE;
                    end else begin
                        n_open = 1'b0;
                        w_kind = icnf_pkg::KIND_CLAUSE;
                    end
                end else if (r_phase == PH_NUMBER) begin
                    w_put = 1'b1; w_code = icnf_pkg::ERR_AFTER_NUMBER; n_phase = PH_ERROR;
                end
            end
            PH_DONE, PH_ERROR: begin
                // drop everything until reset
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEEK;
            r_hdr_pos   <= '0;
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_open      <= 1'b0;
            r_cube      <= 1'b0;
            r_allowed   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase   <= n_phase;
                r_hdr_pos <= n_hdr_pos;
                r_mag     <= n_mag;
                r_neg     <= n_neg;
                r_open    <= n_open;
                r_cube    <= n_cube;
                r_allowed <= n_allowed;
            end
            if (o_pop && w_put) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_put) begin
            r_kind  <= w_kind;
            r_value <= w_value;
            r_code  <= w_code;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.token_kind    = r_kind;
    assign o_out.literal_value = r_value;
    assign o_out.error_code    = r_code;

`ifndef ASSERT_OFF
    a_silent_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE || r_phase == PH_ERROR) |=> !$rose(r_out_valid))
        else $error("token produced after done or error");
    a_hdr_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEADER && r_phase != PH_ERROR) |-> (r_hdr_pos == '0))
        else $error("header position left nonzero");
    a_literal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == icnf_pkg::KIND_LIT)
            |-> (r_value != '0 && r_value != 32'h8000_0000))
        else $error("literal token with zero or out-of-range value");
    a_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != icnf_pkg::KIND_ERROR)
            |-> (r_code == icnf_pkg::ERR_NONE))
        else $error("error code on a non-error token");
`endif

endmodule

### rtl/icnf_stream_tokenizer.sv
// Top level of the incremental CNF tokenizer.
// Depends on icnf_pkg, icnf_in_if, icnf_out_if, icnf_classify, icnf_queue, icnf_parse.

// The tokenizer takes one word per cycle on i_in: a text byte, or the end
// mark (end_of_input high, byte ignored). It skips 'c' comment lines, demands
// the header line "p inccnf", then emits a token per signed literal, a clause
// end or cube end for each terminating zero ("a" opens a cube line), a done
// token at a clean end, or a single error token with its cause code. After
// done or error, further words are accepted and dropped until reset. Sustained
// rate is one word per cycle while o_out does not stall: the parser consumes
// one queued word each cycle and can retire one token into its output
// register per cycle. A token shows on o_out after the word that causes it
// has passed the queue and the output register. A front classifier tags each
// byte, a short queue (QUEUE_DEPTH words) decouples it from the parser, so
// input keeps flowing while a token waits on o_out until the queue fills.
module icnf_stream_tokenizer #(
    parameter int QUEUE_DEPTH = icnf_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    icnf_in_if.sink     i_in,
    icnf_out_if.source  o_out
);

    logic             w_push;
    logic             w_full;
    logic             w_q_valid;
    logic             w_pop;
    icnf_pkg::t_item  w_in_item;
    icnf_pkg::t_item  w_q_item;

    // Tag each incoming word with its character class.
    icnf_classify u_classify (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_item (w_in_item)
    );

    // Hold classified words until the parser can take them.
    icnf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // Advance the parser and present tokens.
    icnf_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

### tb/icnf_stream_tokenizer_checker.sv
`timescale 1ns / 1ps
// Token checker for icnf_stream_tokenizer: watches both channels and predicts tokens.
// Compares the predicted tokens with the block's output. Depends on icnf_pkg, icnf_in_if, icnf_out_if.
module icnf_stream_tokenizer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    icnf_in_if   i_text,
    icnf_out_if  i_tokens,
    output int   o_fail_count,
    output int   o_pending
);

    typedef enum logic [3:0] {
        PH_SEEK,
        PH_HDR_CMT,
        PH_HDR,
        PH_BODY,
        PH_BODY_CMT,
        PH_MINUS,
        PH_NUM,
        PH_NUM_CMT,
        PH_DONE,
        PH_ERROR
    } t_parse_phase;

    typedef struct packed {
        logic [icnf_pkg::KIND_W-1:0]         kind;
        logic signed [icnf_pkg::VALUE_W-1:0] value;
        logic [icnf_pkg::CODE_W-1:0]         code;
    } t_token;

    // header text after the leading 'p'
    localparam logic [63:0] HEADER_TAIL = {" inccnf", icnf_pkg::CH_NL};

    t_parse_phase               parse_phase;
    logic [2:0]                 hdr_pos;
    logic [icnf_pkg::MAG_W-1:0] magnitude;
    logic                       negative;
    logic                       lit_open;
    logic                       cube_open;
    logic                       clauses_ok;

    t_token expected_tokens[$];
    int     fail_count    = 0;
    int     pending_count = 0;
    int     token_index   = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("token %0d: %s got %0d, want %0d", token_index, what, got, want);
        fail_count++;
    endtask

    task automatic push_token(input logic [icnf_pkg::KIND_W-1:0] kind,
                              input logic signed [icnf_pkg::VALUE_W-1:0] value,
                              input logic [icnf_pkg::CODE_W-1:0] code);
        t_token t;
        t.kind  = kind;
        t.value = value;
        t.code  = code;
        expected_tokens.push_back(t);
    endtask

    // an error is sticky: everything after it is dropped
    task automatic raise_error(input logic [icnf_pkg::CODE_W-1:0] code);
        parse_phase = PH_ERROR;
        push_token(icnf_pkg::KIND_ERROR, '0, code);
    endtask

    // finish the number held in magnitude/negative
    task automatic close_number();
        logic signed [icnf_pkg::VALUE_W-1:0] v;
        parse_phase = PH_BODY;
        v = {1'b0, magnitude};
        if (magnitude != '0) begin
            lit_open = 1'b1;
            push_token(icnf_pkg::KIND_LIT, negative ? -v : v, icnf_pkg::ERR_NONE);
        end else if (!clauses_ok && !cube_open) begin
            raise_error(icnf_pkg::ERR_CLAUSE_AFTER);
        end else begin
            lit_open = 1'b0;
            if (cube_open) begin
                cube_open  = 1'b0;
                clauses_ok = 1'b0;
                push_token(icnf_pkg::KIND_CUBE, '0, icnf_pkg::ERR_NONE);
            end else begin
                push_token(icnf_pkg::KIND_CLAUSE, '0, icnf_pkg::ERR_NONE);
            end
        end
    endtask

    task automatic predict_word(input logic eof, input logic [7:0] ch);
        logic        digit;
        logic        blank;
        logic [35:0] grown;
        digit = (ch >= icnf_pkg::CH_ZERO) && (ch <= icnf_pkg::CH_NINE);
        blank = (ch == icnf_pkg::CH_SPACE) || (ch == icnf_pkg::CH_TAB)
                || (ch == icnf_pkg::CH_NL);
        case (parse_phase)
            PH_SEEK: begin
                if (eof) raise_error(icnf_pkg::ERR_EOF_NO_HDR);
                else if (ch == icnf_pkg::CH_C) parse_phase = PH_HDR_CMT;
                else if (ch == icnf_pkg::CH_P) begin
                    parse_phase = PH_HDR;
                    hdr_pos = '0;
                end else raise_error(icnf_pkg::ERR_BAD_PRE_HDR);
            end
            PH_HDR_CMT: begin
                if (eof) raise_error(icnf_pkg::ERR_EOF_HDR_CMT);
                else if (ch == icnf_pkg::CH_NL) parse_phase = PH_SEEK;
            end
            PH_HDR: begin
                if (eof || ch != HEADER_TAIL[63 - 8 * int'(hdr_pos) -: 8])
                    raise_error(icnf_pkg::ERR_BAD_HDR);
                else if (hdr_pos == 3'd7) begin
                    parse_phase = PH_BODY;
                    hdr_pos = '0;
                end else hdr_pos++;
            end
            PH_BODY: begin
                if (eof) begin
                    if (lit_open) raise_error(icnf_pkg::ERR_EOF_OPEN);
                    else if (cube_open) raise_error(icnf_pkg::ERR_EOF_AFTER_A);
                    else begin
                        parse_phase = PH_DONE;
                        push_token(icnf_pkg::KIND_DONE, '0, icnf_pkg::ERR_NONE);
                    end
                end else if (blank) begin
                end else if (ch == icnf_pkg::CH_C) parse_phase = PH_BODY_CMT;
                else if (ch == icnf_pkg::CH_A) begin
                    if (cube_open) raise_error(icnf_pkg::ERR_DOUBLE_A);
                    else if (lit_open) raise_error(icnf_pkg::ERR_A_OPEN);
                    else cube_open = 1'b1;
                end else if (ch == icnf_pkg::CH_MINUS) parse_phase = PH_MINUS;
                else if (digit) begin
                    magnitude   = icnf_pkg::MAG_W'(ch - icnf_pkg::CH_ZERO);
                    negative    = 1'b0;
                    parse_phase = PH_NUM;
                end else raise_error(icnf_pkg::ERR_UNEXPECTED);
            end
            PH_BODY_CMT: begin
                if (eof) raise_error(icnf_pkg::ERR_EOF_CMT);
                else if (ch == icnf_pkg::CH_NL) parse_phase = PH_BODY;
            end
            PH_MINUS: begin
                if (eof || !digit) raise_error(icnf_pkg::ERR_MINUS_NODIGIT);
                else if (ch == icnf_pkg::CH_ZERO) raise_error(icnf_pkg::ERR_MINUS_ZERO);
                else begin
                    magnitude   = icnf_pkg::MAG_W'(ch - icnf_pkg::CH_ZERO);
                    negative    = 1'b1;
                    parse_phase = PH_NUM;
                end
            end
            PH_NUM: begin
                if (eof) raise_error(icnf_pkg::ERR_AFTER_NUMBER);
                else if (digit) begin
                    grown = 36'(magnitude) * 36'd10 + 36'(ch - icnf_pkg::CH_ZERO);
                    if (grown > 36'(icnf_pkg::MAX_MAG)) raise_error(icnf_pkg::ERR_OVERFLOW);
                    else magnitude = grown[icnf_pkg::MAG_W-1:0];
                end else if (ch == icnf_pkg::CH_C) parse_phase = PH_NUM_CMT;
                else if (blank) close_number();
                else raise_error(icnf_pkg::ERR_AFTER_NUMBER);
            end
            PH_NUM_CMT: begin
                if (eof) raise_error(icnf_pkg::ERR_EOF_CMT);
                else if (ch == icnf_pkg::CH_NL) close_number();
            end
            default: ;
        endcase
    endtask

    task automatic check_token();
        t_token got;
        t_token want;
        got.kind  = i_tokens.token_kind;
        got.value = i_tokens.literal_value;
        got.code  = i_tokens.error_code;
        if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected token, kind", got.kind, -1);
        end else begin
            want = expected_tokens.pop_front();
            if (got.kind != want.kind) report_mismatch("token_kind", got.kind, want.kind);
            if (got.value != want.value)
                report_mismatch("literal_value", got.value, want.value);
            if (got.code != want.code) report_mismatch("error_code", got.code, want.code);
        end
        token_index++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_phase = PH_SEEK;
            hdr_pos     = '0;
            magnitude   = '0;
            negative    = 1'b0;
            lit_open    = 1'b0;
            cube_open   = 1'b0;
            clauses_ok  = 1'b1;
            expected_tokens.delete();
        end else begin
            if (i_text.valid && i_text.ready)
                predict_word(i_text.end_of_input, i_text.in_byte);
            if (i_tokens.valid && i_tokens.ready)
                check_token();
        end
        pending_count <= expected_tokens.size();
    end

endmodule

### tb/icnf_stream_tokenizer_test.sv
`timescale 1ns / 1ps
// Top of the icnf_stream_tokenizer testbench: builds one CNF text, drives it, stalls tokens.
// Depends on icnf_pkg, icnf_in_if, icnf_out_if, the block and icnf_stream_tokenizer_checker.
module icnf_stream_tokenizer_test;

    localparam int TEXT_TARGET      = 1650;  // random body length in words
    localparam int LONG_HOLD_AT     = 400;   // cycle after reset of the long token stall
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int TAIL_CYCLES      = 20;
    localparam logic [7:0] BLANKS [3] =
        '{icnf_pkg::CH_SPACE, icnf_pkg::CH_TAB, icnf_pkg::CH_NL};

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    // whole text to send, one word each: {end mark, byte}
    logic [8:0] text_q[$];

    icnf_in_if  in_ch ();
    icnf_out_if out_ch ();

    icnf_stream_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    icnf_stream_tokenizer_checker token_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text       (in_ch),
        .i_tokens     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case tokens go missing or a handshake hangs.
    initial begin
        #2_000_000;
        $display("icnf_stream_tokenizer_test NOT OK");
        $finish;
    end

    task automatic put_byte(input logic [7:0] b);
        text_q.push_back({1'b0, b});
    endtask

    task automatic put_text(input string s);
        foreach (s[i]) put_byte(s[i]);
    endtask

    // End mark: the byte rides along but must be ignored, so randomize it.
    task automatic put_end();
        text_q.push_back({1'b1, 8'($urandom_range(255))});
    endtask

    // Comment: 'c', up to six random bytes other than newline, and the closing newline if asked.
    task automatic put_comment(input bit closed);
        logic [7:0] b;
        put_byte(icnf_pkg::CH_C);
        repeat ($urandom_range(6)) begin
            do b = 8'($urandom_range(255)); while (b == icnf_pkg::CH_NL);
            put_byte(b);
        end
        if (closed) put_byte(icnf_pkg::CH_NL);
    endtask

    // Separator after a number: mostly blanks, sometimes a comment that
    // closes the number by itself, sometimes blanks then a comment line.
    task automatic put_gap();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            put_comment(1'b1);
        end else begin
            repeat ($urandom_range(3, 1)) put_byte(BLANKS[$urandom_range(2)]);
            if (sel == 1) put_comment(1'b1);
        end
    endtask

    // Signed literal: small values dominate, extremes show up now and then.
    task automatic put_literal();
        int unsigned sel;
        int unsigned mag;
        sel = $urandom_range(99);
        if (sel < 55)      mag = $urandom_range(30, 1);
        else if (sel < 80) mag = $urandom_range(100000, 1);
        else if (sel < 92) mag = $urandom_range(32'h7FFF_FFFF, 1);
        else if (sel < 96) mag = 32'h7FFF_FFFF;
        else               mag = 1;
        if ($urandom_range(1)) begin
            put_byte(icnf_pkg::CH_MINUS);
        end else if ($urandom_range(9) == 0) begin
            // leading zeros are legal on positive literals
            if ($urandom_range(1)) put_text("0");
            else put_text("00");
        end
        put_text($sformatf("%0d", mag));
        put_gap();
    endtask

    // Sender: build the text, release reset, then push every word through
    // the input channel in bursts with random gaps.
    initial begin : source_side
        int unsigned clause_stop;
        int unsigned body_stop;
        int unsigned ending;
        int unsigned big;
        int unsigned burst_left;
        int unsigned pause_at;
        logic [7:0]  b;

        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.in_byte      = 8'h00;
        in_ch.end_of_input = 1'b0;

        // Opening: comment with all-ones and all-zeros bytes ahead of the
        // header, the header itself, a zero-padded literal closed by a
        // comment, a double-zero clause end and a short negative clause.
        put_byte(icnf_pkg::CH_C);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(icnf_pkg::CH_NL);
        put_text("p inccnf");
        put_byte(icnf_pkg::CH_NL);
        put_text("007c");
        put_byte(8'hA5);
        put_byte(icnf_pkg::CH_NL);
        put_text("00\t-1 0 ");

        // Body: clauses first, then cube lines; once a cube has closed no
        // clause may follow, so the switch happens once.
        clause_stop = text_q.size() + $urandom_range(TEXT_TARGET * 8 / 10, TEXT_TARGET / 5);
        body_stop   = text_q.size() + TEXT_TARGET;
        while (text_q.size() < body_stop) begin
            if (text_q.size() >= clause_stop) begin
                put_byte(icnf_pkg::CH_A);
                if ($urandom_range(1)) put_gap();
            end
            repeat ($urandom_range(5)) put_literal();
            if ($urandom_range(4) == 0) put_text("00");
            else put_text("0");
            put_gap();
        end

        // Close the text: a clean end, or one of the faults the body allows.
        ending = $urandom_range(18, 4);
        case (ending)
            icnf_pkg::ERR_EOF_CMT: begin
                put_comment(1'b0);
                put_end();
            end
            icnf_pkg::ERR_DOUBLE_A:  put_text("aa");
            icnf_pkg::ERR_A_OPEN:    put_text("5 a");
            icnf_pkg::ERR_MINUS_NODIGIT: begin
                put_byte(icnf_pkg::CH_MINUS);
                if ($urandom_range(1)) put_end();
                else put_byte(icnf_pkg::CH_SPACE);
            end
            icnf_pkg::ERR_MINUS_ZERO: put_text("-0");
            icnf_pkg::ERR_UNEXPECTED: begin
                do b = 8'($urandom_range(255));
                while (b == icnf_pkg::CH_SPACE || b == icnf_pkg::CH_TAB
                       || b == icnf_pkg::CH_NL || b == icnf_pkg::CH_C
                       || b == icnf_pkg::CH_A || b == icnf_pkg::CH_MINUS
                       || (b >= icnf_pkg::CH_ZERO && b <= icnf_pkg::CH_NINE));
                put_byte(b);
            end
            icnf_pkg::ERR_OVERFLOW: begin
                big = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
                put_text($sformatf("%0d", big));
            end
            icnf_pkg::ERR_CLAUSE_AFTER: put_text("a 0 0 ");
            icnf_pkg::ERR_EOF_OPEN: begin
                put_text("5 ");
                put_end();
            end
            icnf_pkg::ERR_EOF_AFTER_A: begin
                put_byte(icnf_pkg::CH_A);
                put_end();
            end
            icnf_pkg::ERR_AFTER_NUMBER: begin
                put_text("12");
                if ($urandom_range(1)) put_end();
                else put_byte(icnf_pkg::CH_P);
            end
            default: put_end();
        endcase

        // Trailing words after the final token; the block must drop them.
        repeat (16) text_q.push_back({1'($urandom_range(1)), 8'($urandom_range(255))});

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        burst_left = 0;
        pause_at   = $urandom_range(text_q.size() * 3 / 4, text_q.size() / 4);
        for (int k = 0; k < text_q.size(); k++) begin
            if (k == pause_at) begin
                // hold the text until every predicted token has come out
                in_ch.valid <= 1'b0;
                do @(negedge i_clk); while (pending != 0);
            end
            if (burst_left == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(negedge i_clk);
                // mostly short bursts, now and then a long unbroken stretch
                if ($urandom_range(3) == 0) burst_left = $urandom_range(150, 40);
                else burst_left = $urandom_range(12, 1);
            end
            burst_left--;
            in_ch.valid        <= 1'b1;
            in_ch.in_byte      <= text_q[k][7:0];
            in_ch.end_of_input <= text_q[k][8];
            do @(posedge i_clk); while (!in_ch.ready);
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b0;

        // Drain: wait for the last token, then wait out TAIL_CYCLES so that
        // any stray token still shows up at the checker.
        do @(negedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("icnf_stream_tokenizer_test OK");
        end else begin
            $display("icnf_stream_tokenizer_test NOT OK");
        end
        $finish;
    end

    // Receiver: ready steps through four patterns in turn, and
    // once drops for a long stretch so the queue fills and stalls the text.
    initial begin : sink_side
        int unsigned cyc;
        out_ch.ready = 1'b0;
        cyc = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc == LONG_HOLD_AT) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                case ((cyc / 128) % 4)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(1));
                    2:       out_ch.ready <= (cyc % 5 == 0);
                    default: out_ch.ready <= ($urandom_range(9) != 0);
                endcase
            end
        end
    end

endmodule

### filelist.f
rtl/icnf_pkg.sv
rtl/icnf_in_if.sv
rtl/icnf_out_if.sv
rtl/icnf_classify.sv
rtl/icnf_queue.sv
rtl/icnf_parse.sv
rtl/icnf_stream_tokenizer.sv
tb/icnf_stream_tokenizer_checker.sv
tb/icnf_stream_tokenizer_test.sv
